// ----- src/rcd_pkg.sv -----
// ----------------------------------------------------------------------------
// rcd_pkg: shared types and constants for the rank compressor
// Beat payloads, status codes and the cell control group.
// ----------------------------------------------------------------------------
`default_nettype none

package rcd_pkg;

  localparam int unsigned DEFAULT_MAX_COUNT = 64;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_DUP  = 2'd1;
  localparam logic [1:0] STATUS_MANY = 2'd2;

  localparam logic [1:0] EQ_SAT = 2'd2;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } rcd_in_t;

  typedef struct packed {
    logic [5:0] rank;
    logic [1:0] status;
    logic       last_res;
  } rcd_out_t;

  typedef struct packed {
    logic shift;
    logic cmp;
    logic bvalid;
  } rcd_ctl_t;

endpackage

`default_nettype wire

// ----- src/rcd_cell.sv -----
// ----------------------------------------------------------------------------
// rcd_cell: one slot of the value ring
// Holds a value with its running rank and equal-hit count; compares the
// entry it takes from its neighbor against the broadcast value.
// ----------------------------------------------------------------------------
`default_nettype none

module rcd_cell #(
  parameter int unsigned RW = 6
) (
  input  wire logic                clk_i,
  input  wire rcd_pkg::rcd_ctl_t   ctl_i,
  input  wire logic signed [31:0]  bval_i,
  input  wire logic signed [31:0]  val_i,
  input  wire logic [RW-1:0]       rank_i,
  input  wire logic [1:0]          eq_i,
  output logic signed [31:0]       val_o,
  output logic [RW-1:0]            rank_o,
  output logic [1:0]               eq_o
);
  import rcd_pkg::*;

  logic signed [31:0] val_q;
  logic [RW-1:0]      rank_q, rank_d;
  logic [1:0]         eq_q, eq_d;

  always_comb begin
    rank_d = rank_i;
    eq_d   = eq_i;
    if (ctl_i.cmp && ctl_i.bvalid) begin
      if (bval_i < val_i) begin
        rank_d = rank_i + 1'b1;
      end
      if (bval_i == val_i && eq_i != EQ_SAT) begin
        eq_d = eq_i + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      val_q  <= val_i;
      rank_q <= rank_d;
      eq_q   <= eq_d;
    end
  end

  assign val_o  = val_q;
  assign rank_o = rank_q;
  assign eq_o   = eq_q;

endmodule

`default_nettype wire

// ----- src/rank_compress_with_dup_check.sv -----
// ----------------------------------------------------------------------------
// rank_compress_with_dup_check: rank of each value within a set
// Values shift into a ring of cells; the ring then rotates while the tail
// cell broadcasts, so every cell counts the smaller values it meets.
//
//   channel  beat       handshake                 payload
//   input    one value  start_i & !busy_o         item_i  (rcd_in_t)
//   result   one rank   res_valid_o, one cycle    res_o   (rcd_out_t)
//
// Loading accepts back-to-back values while busy_o is low. After the last
// value the ring turns once round per pass: compare, duplicate sweep and,
// for a set with no duplicate, output. busy_o stays high through each pass;
// each result beat trails its ring cycle by one register stage.
// A too-many result comes in the cycle after the last value, with no busy time.
// Results are never stalled. Reset clears the control state only.
// ----------------------------------------------------------------------------
`default_nettype none

module rank_compress_with_dup_check #(
  parameter int unsigned MAX_COUNT = rcd_pkg::DEFAULT_MAX_COUNT
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire rcd_pkg::rcd_in_t item_i,
  output logic                  busy_o,
  output logic                  res_valid_o,
  output rcd_pkg::rcd_out_t     res_o
);
  import rcd_pkg::*;

  localparam int unsigned N  = MAX_COUNT;
  localparam int unsigned KW = $clog2(N);
  localparam int unsigned CW = $clog2(N + 1);
  localparam int unsigned RW = KW;
  localparam logic [CW-1:0] NC   = CW'(N);
  localparam logic [KW-1:0] KEND = KW'(N - 1);

  typedef enum logic [3:0] {
    ST_LOAD = 4'b0001,
    ST_CMP  = 4'b0010,
    ST_DUP  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          over_q, over_d;
  logic [KW-1:0] k_q, k_d;
  logic          dup_q, dup_d;
  logic          res_valid_q, res_valid_d;
  rcd_out_t      res_q, res_d;

  logic signed [31:0] val  [N];
  logic [RW-1:0]      rank [N];
  logic [1:0]         eq   [N];

  logic signed [31:0] head_val;
  logic [RW-1:0]      head_rank;
  logic [1:0]         head_eq;
  rcd_ctl_t           ctl;
  logic               accept, full, dup_now;
  logic [RW+5:0]      rank_w;

  assign accept = start_i && (state_q == ST_LOAD);
  assign full   = (cnt_q == NC);

  always_comb begin
    ctl.bvalid = ({1'b0, k_q} >= (NC - cnt_q));
    ctl.cmp    = (state_q == ST_CMP);
    ctl.shift  = (state_q == ST_LOAD) ? (accept && !full) : 1'b1;
    if (state_q == ST_LOAD) begin
      head_val  = item_i.value;
      head_rank = '0;
      head_eq   = '0;
    end else begin
      head_val  = val[N-1];
      head_rank = rank[N-1];
      head_eq   = eq[N-1];
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_head
      rcd_cell #(.RW(RW)) u_cell (
        .clk_i (clk_i),
        .ctl_i (ctl),
        .bval_i(val[N-1]),
        .val_i (head_val),
        .rank_i(head_rank),
        .eq_i  (head_eq),
        .val_o (val[i]),
        .rank_o(rank[i]),
        .eq_o  (eq[i])
      );
    end else begin : g_body
      rcd_cell #(.RW(RW)) u_cell (
        .clk_i (clk_i),
        .ctl_i (ctl),
        .bval_i(val[N-1]),
        .val_i (val[i-1]),
        .rank_i(rank[i-1]),
        .eq_i  (eq[i-1]),
        .val_o (val[i]),
        .rank_o(rank[i]),
        .eq_o  (eq[i])
      );
    end
  end

  assign dup_now = dup_q || (ctl.bvalid && eq[N-1] == EQ_SAT);
  assign rank_w  = {6'b0, rank[N-1]};

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    over_d      = over_q;
    k_d         = k_q;
    dup_d       = dup_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    unique case (state_q)
      ST_LOAD: begin
        if (accept) begin
          if (full) begin
            over_d = 1'b1;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
          if (item_i.last) begin
            if (full || over_q) begin
              res_valid_d = 1'b1;
              res_d       = '{rank: 6'd0, status: STATUS_MANY, last_res: 1'b1};
              cnt_d       = '0;
              over_d      = 1'b0;
            end else begin
              state_d = ST_CMP;
              k_d     = '0;
              dup_d   = 1'b0;
            end
          end
        end
      end
      ST_CMP: begin
        k_d = k_q + 1'b1;
        if (k_q == KEND) begin
          k_d     = '0;
          state_d = ST_DUP;
        end
      end
      ST_DUP: begin
        k_d   = k_q + 1'b1;
        dup_d = dup_now;
        if (k_q == KEND) begin
          k_d = '0;
          if (dup_now) begin
            res_valid_d = 1'b1;
            res_d       = '{rank: 6'd0, status: STATUS_DUP, last_res: 1'b1};
            state_d     = ST_LOAD;
            cnt_d       = '0;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        k_d = k_q + 1'b1;
        if (ctl.bvalid) begin
          res_valid_d = 1'b1;
          res_d       = '{rank: rank_w[5:0], status: STATUS_OK, last_res: (k_q == KEND)};
        end
        if (k_q == KEND) begin
          k_d     = '0;
          state_d = ST_LOAD;
          cnt_d   = '0;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      over_q      <= 1'b0;
      k_q         <= '0;
      dup_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      over_q      <= over_d;
      k_q         <= k_d;
      dup_q       <= dup_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy_o      = (state_q != ST_LOAD);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ----- src/rcd_checker.sv -----
// ----------------------------------------------------------------------------
// rcd_checker: port-level checks for the rank compressor
// Watches the input and result beats over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rcd_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start_i,
  input wire rcd_pkg::rcd_in_t  item_i,
  input wire logic              busy_o,
  input wire logic              res_valid_o,
  input wire rcd_pkg::rcd_out_t res_o
);
  import rcd_pkg::*;

  // error beats close the run
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status != STATUS_OK |-> res_o.last_res)
    else $error("error beat without last_res");

  a_err_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status != STATUS_OK |-> res_o.rank == 6'd0)
    else $error("error beat with nonzero rank");

  // a value that does not close the set gives no beat
  a_mid_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && !item_i.last |=> !res_valid_o)
    else $error("result beat after an intermediate value");

  // ranks stream only while the ring is turning, until the final one
  a_ok_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.status == STATUS_OK && !res_o.last_res |-> busy_o)
    else $error("rank beat while idle");

endmodule

bind rank_compress_with_dup_check rcd_checker u_rcd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .item_i     (item_i),
  .busy_o     (busy_o),
  .res_valid_o(res_valid_o),
  .res_o      (res_o)
);

`default_nettype wire
